[src/afsd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package afsd_pkg;

  // Samples summed into one window.
  localparam int unsigned SAMPLES_PER_WINDOW = 10;

  localparam int unsigned ACCEL_W = 16;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned THR_W   = 39;
  localparam int unsigned FACE_W  = 3;

  // A window sum holds SAMPLES_PER_WINDOW full-scale samples without wrapping.
  localparam int unsigned SUM_W = ACCEL_W + $clog2(SAMPLES_PER_WINDOW);
  localparam int unsigned SQ_W  = 2 * SUM_W;
  localparam int unsigned SQS_W = SQ_W + 2;
  localparam int unsigned CMP_W = (SQS_W > THR_W) ? SQS_W : THR_W;
  localparam int unsigned CNT_W = (SAMPLES_PER_WINDOW > 1) ?
                                  $clog2(SAMPLES_PER_WINDOW) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_WINDOW - 1);

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = THR_W;

  localparam logic [CFG_IDX_W-1:0] REG_SHAKE_THRESHOLD_SQ = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHAKE_HOLDOFF_US   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHAKE_ENABLE       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FACE_ENABLE        = 3'd3;

  localparam logic [THR_W-1:0]  THRESHOLD_RESET = 39'd300000000;
  localparam logic [TIME_W-1:0] HOLDOFF_RESET   = 32'd1500000;

  // Face codes are {axis, positive}; the none code follows the six faces.
  localparam logic [FACE_W-1:0] FACE_NONE = 3'd6;
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic signed [ACCEL_W-1:0] accel_x;
    logic signed [ACCEL_W-1:0] accel_y;
    logic signed [ACCEL_W-1:0] accel_z;
    logic                      sample_ok;
    logic [TIME_W-1:0]         time_us;
  } afsd_in_t;

  typedef struct packed {
    logic              shake_event;
    logic              face_changed;
    logic [FACE_W-1:0] face_code;
  } afsd_out_t;

endpackage

`default_nettype wire

[src/accel_face_and_shake_detector_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel | Direction | Handshake          | Word
// in_     | input     | in_valid/in_stall  | afsd_in_t: one three-axis sample
// out_    | output    | out_valid/out_stall| afsd_out_t: one result per window
// cfg_    | input     | cfg_valid/cfg_ready| register index and write data
//
// One sample word is taken every clock cycle while in_stall is low; the
// accumulator adders set the pace. After the window's last sample is accepted, a
// result is built in steps: accumulate, square the sums, threshold and face decision.
// Synchronous active-low reset clears the sums, the window count, the last shake
// time, sets the stored face to none and loads the register defaults.
// A stall on the result side fills the stages in turn; in_stall rises only once
// the input register holds a window-closing sample that cannot move on.
module accel_face_and_shake_detector_top (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire  afsd_pkg::afsd_in_t            in_data,
  output logic                                out_valid,
  input  wire                                 out_stall,
  output afsd_pkg::afsd_out_t                 out_data,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire  [afsd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [afsd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import afsd_pkg::*;

  // Configuration registers.
  logic [THR_W-1:0]  thresh_r;
  logic [TIME_W-1:0] holdoff_r;
  logic              shake_en_r;
  logic              face_en_r;

  // Input register.
  logic     in_valid_r;
  afsd_in_t in_data_r;

  // Window accumulators.
  logic [CNT_W-1:0]        cnt_r;
  logic signed [SUM_W-1:0] sum_x_r, sum_y_r, sum_z_r;

  // Finished window sums.
  logic                    fin_valid_r;
  logic signed [SUM_W-1:0] fin_x_r, fin_y_r, fin_z_r;
  logic [TIME_W-1:0]       fin_time_r;

  // Squares stage.
  logic              sq_valid_r;
  logic [SQ_W-1:0]   sq_x_r, sq_y_r, sq_z_r;
  logic              pos_x_r, pos_y_r, pos_z_r;
  logic [TIME_W-1:0] sq_time_r;

  // Decision state and output register.
  logic [TIME_W-1:0] last_shake_r;
  logic [FACE_W-1:0] stored_face_r;
  logic              out_valid_r;
  afsd_out_t         out_data_r;

  logic                    win_end;
  logic                    consume;
  logic                    in_load;
  logic                    fin_adv;
  logic                    sq_adv;
  logic                    out_adv;
  logic signed [SUM_W-1:0] add_x, add_y, add_z;
  logic signed [SUM_W-1:0] sum_x_nxt, sum_y_nxt, sum_z_nxt;
  logic [SUM_W-1:0]        mag_x, mag_y, mag_z;
  logic [SQS_W-1:0]        sq_sum;
  logic                    over_thresh;
  logic                    past_holdoff;
  logic                    shake_hit;
  logic [1:0]              axis;
  logic [SQ_W-1:0]         sq_sel;
  logic                    pos_sel;
  logic [FACE_W-1:0]       face_new;
  afsd_out_t               out_data_nxt;
  logic [TIME_W-1:0]       last_shake_nxt;
  logic [FACE_W-1:0]       stored_face_nxt;

  // Each stage moves forward when it is empty or the stage after it moves.
  assign out_adv  = !out_valid_r || !out_stall;
  assign sq_adv   = !sq_valid_r || out_adv;
  assign fin_adv  = !fin_valid_r || sq_adv;
  assign win_end  = (cnt_r == CNT_LAST);
  // Only a sample that closes a window needs room downstream.
  assign consume  = in_valid_r && (!win_end || fin_adv);
  assign in_stall = in_valid_r && !consume;
  assign in_load  = in_valid && !in_stall;

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A failed read still takes its slot but adds zero.
  always_comb begin
    add_x = '0;
    add_y = '0;
    add_z = '0;
    if (in_data_r.sample_ok) begin
      add_x = {{(SUM_W-ACCEL_W){in_data_r.accel_x[ACCEL_W-1]}}, in_data_r.accel_x};
      add_y = {{(SUM_W-ACCEL_W){in_data_r.accel_y[ACCEL_W-1]}}, in_data_r.accel_y};
      add_z = {{(SUM_W-ACCEL_W){in_data_r.accel_z[ACCEL_W-1]}}, in_data_r.accel_z};
    end
    sum_x_nxt = sum_x_r + add_x;
    sum_y_nxt = sum_y_r + add_y;
    sum_z_nxt = sum_z_r + add_z;
  end

  // Magnitudes; the most negative sum maps onto its unsigned magnitude correctly.
  assign mag_x = fin_x_r[SUM_W-1] ? SUM_W'(-fin_x_r) : SUM_W'(fin_x_r);
  assign mag_y = fin_y_r[SUM_W-1] ? SUM_W'(-fin_y_r) : SUM_W'(fin_y_r);
  assign mag_z = fin_z_r[SUM_W-1] ? SUM_W'(-fin_z_r) : SUM_W'(fin_z_r);

  // Window-end decision: threshold with holdoff, and the dominant axis.
  always_comb begin
    sq_sum       = SQS_W'(sq_x_r) + SQS_W'(sq_y_r) + SQS_W'(sq_z_r);
    over_thresh  = CMP_W'(sq_sum) > CMP_W'(thresh_r);
    past_holdoff = (sq_time_r - last_shake_r) > holdoff_r;
    shake_hit    = shake_en_r && over_thresh && past_holdoff;

    // Strict compares, so a tie keeps the earlier axis.
    axis    = AXIS_X;
    sq_sel  = sq_x_r;
    pos_sel = pos_x_r;
    if (sq_y_r > sq_x_r) begin
      axis    = AXIS_Y;
      sq_sel  = sq_y_r;
      pos_sel = pos_y_r;
    end
    if (sq_z_r > sq_sel) begin
      axis    = AXIS_Z;
      pos_sel = pos_z_r;
    end
    face_new = {axis, pos_sel};

    out_data_nxt.shake_event  = shake_hit;
    out_data_nxt.face_changed = face_en_r && (face_new != stored_face_r);
    out_data_nxt.face_code    = face_en_r ? face_new : stored_face_r;

    last_shake_nxt  = shake_hit ? sq_time_r : last_shake_r;
    stored_face_nxt = face_en_r ? face_new : stored_face_r;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r      <= THRESHOLD_RESET;
      holdoff_r     <= HOLDOFF_RESET;
      shake_en_r    <= 1'b0;
      face_en_r     <= 1'b0;
      in_valid_r    <= 1'b0;
      cnt_r         <= '0;
      sum_x_r       <= '0;
      sum_y_r       <= '0;
      sum_z_r       <= '0;
      fin_valid_r   <= 1'b0;
      sq_valid_r    <= 1'b0;
      last_shake_r  <= '0;
      stored_face_r <= FACE_NONE;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SHAKE_THRESHOLD_SQ: thresh_r   <= cfg_wdata[THR_W-1:0];
          REG_SHAKE_HOLDOFF_US:   holdoff_r  <= cfg_wdata[TIME_W-1:0];
          REG_SHAKE_ENABLE:       shake_en_r <= cfg_wdata[0];
          REG_FACE_ENABLE:        face_en_r  <= cfg_wdata[0];
          default: ;
        endcase
      end

      if (in_load) begin
        in_valid_r <= 1'b1;
      end else if (consume) begin
        in_valid_r <= 1'b0;
      end

      if (consume) begin
        if (win_end) begin
          cnt_r   <= '0;
          sum_x_r <= '0;
          sum_y_r <= '0;
          sum_z_r <= '0;
        end else begin
          cnt_r   <= cnt_r + 1'b1;
          sum_x_r <= sum_x_nxt;
          sum_y_r <= sum_y_nxt;
          sum_z_r <= sum_z_nxt;
        end
      end

      if (consume && win_end) begin
        fin_valid_r <= 1'b1;
      end else if (sq_adv) begin
        fin_valid_r <= 1'b0;
      end

      if (sq_adv) begin
        sq_valid_r <= fin_valid_r;
      end

      if (out_adv) begin
        out_valid_r <= sq_valid_r;
        if (sq_valid_r) begin
          last_shake_r  <= last_shake_nxt;
          stored_face_r <= stored_face_nxt;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_load) begin
      in_data_r <= in_data;
    end
    if (consume && win_end) begin
      fin_x_r    <= sum_x_nxt;
      fin_y_r    <= sum_y_nxt;
      fin_z_r    <= sum_z_nxt;
      fin_time_r <= in_data_r.time_us;
    end
    if (sq_adv) begin
      sq_x_r    <= SQ_W'(mag_x * mag_x);
      sq_y_r    <= SQ_W'(mag_y * mag_y);
      sq_z_r    <= SQ_W'(mag_z * mag_z);
      pos_x_r   <= !fin_x_r[SUM_W-1] && (fin_x_r != '0);
      pos_y_r   <= !fin_y_r[SUM_W-1] && (fin_y_r != '0);
      pos_z_r   <= !fin_z_r[SUM_W-1] && (fin_z_r != '0);
      sq_time_r <= fin_time_r;
    end
    if (out_adv && sq_valid_r) begin
      out_data_r <= out_data_nxt;
    end
  end

`ifndef SYNTHESIS
  // The window count never runs past the last slot.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_LAST)
    else $error("window count out of range");

  // A face change is only reported while face detection is on.
  a_face_en: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.face_changed) |-> face_en_r)
    else $error("face change with face detection off");

  // A shake is only reported while shake detection is on.
  a_shake_en: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.shake_event) |-> shake_en_r)
    else $error("shake with shake detection off");

  // The reported face is the face kept for the next window.
  a_face_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_adv && sq_valid_r) |=> (out_data_r.face_code == stored_face_r))
    else $error("reported face differs from stored face");

  // The input side only stalls while the input register is full.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid_r |-> !in_stall)
    else $error("stall with empty input register");
`endif

endmodule

`default_nettype wire

[tb/sv/accel_face_and_shake_detector_top_test.sv]
`timescale 1ns / 1ps

module accel_face_and_shake_detector_top_test;
  import afsd_pkg::*;

  // Summed squares of three full-scale window sums: 3 * (10 * 32768)^2.
  localparam logic [THR_W-1:0] FULL_SCALE_ENERGY = 39'd322122547200;
  // Margin for the result to leave after the closing sample is taken.
  localparam int SETTLE_CYCLES = 8;

  typedef enum {
    MOTION_STILL, MOTION_SHAKE, MOTION_FULL, MOTION_DEAD, MOTION_TIE, MOTION_NOISE
  } motion_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  afsd_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  afsd_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  accel_face_and_shake_detector_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Our own copy of the detector: register settings and window state. It is
  // advanced once for every sample word the block accepts.
  logic [THR_W-1:0] thr_sq = THRESHOLD_RESET;
  logic [TIME_W-1:0] holdoff = HOLDOFF_RESET;
  logic shake_on = 1'b0;
  logic face_on = 1'b0;
  int win_fill = 0;
  longint acc [3] = '{0, 0, 0};
  logic [TIME_W-1:0] last_shake_us = '0;
  logic [FACE_W-1:0] face_held = FACE_NONE;

  // Window results still owed by the block, oldest first.
  afsd_out_t pending_results [$];
  int mismatches = 0;

  // Idling knobs, changed from phase to phase.
  int sender_gap_pct = 0;
  int sink_stall_pct = 0;
  int stall_left = 0;

  // Stimulus state for the motion generator.
  motion_t motion = MOTION_STILL;
  int m_axis = 0;
  int m_mag = 1000;
  int m_sign [3] = '{1, 1, 1};
  bit m_ztie = 1'b0;
  logic [TIME_W-1:0] time_clock = '0;

  // Mostly short idle stretches, now and then a long one.
  function automatic int pick_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  function automatic int pick_gap();
    return ($urandom_range(0, 99) < sender_gap_pct) ? pick_len() : 0;
  endfunction

  function automatic afsd_in_t mk(logic [ACCEL_W-1:0] x, logic [ACCEL_W-1:0] y,
                                  logic [ACCEL_W-1:0] z, logic ok, logic [TIME_W-1:0] t);
    afsd_in_t s;
    s.accel_x = x;
    s.accel_y = y;
    s.accel_z = z;
    s.sample_ok = ok;
    s.time_us = t;
    return s;
  endfunction

  // Add one accepted sample to the window. On the last slot of a window this
  // decides shake and face exactly as the block must and queues the result.
  function automatic void fold_sample(input afsd_in_t s);
    longint sq [3];
    logic [1:0] ax;
    logic [TIME_W-1:0] since;
    afsd_out_t r;
    // A failed read still uses its slot, it just adds nothing.
    if (s.sample_ok) begin
      acc[0] += longint'(s.accel_x);
      acc[1] += longint'(s.accel_y);
      acc[2] += longint'(s.accel_z);
    end
    win_fill++;
    if (win_fill < SAMPLES_PER_WINDOW) return;
    for (int k = 0; k < 3; k++) sq[k] = acc[k] * acc[k];
    r = '0;
    r.face_code = face_held;
    // The holdoff is measured with wrapping 32-bit subtraction.
    since = s.time_us - last_shake_us;
    if (shake_on && (sq[0] + sq[1] + sq[2] > longint'(thr_sq)) && since > holdoff) begin
      r.shake_event = 1'b1;
      last_shake_us = s.time_us;
    end
    // Strict compares: on a tie the earlier axis wins, and a zero sum is a
    // negative face.
    if (face_on) begin
      ax = AXIS_X;
      if (sq[AXIS_Y] > sq[ax]) ax = AXIS_Y;
      if (sq[AXIS_Z] > sq[ax]) ax = AXIS_Z;
      r.face_code = {ax, (acc[ax] > 0)};
      if (r.face_code != face_held) begin
        r.face_changed = 1'b1;
        face_held = r.face_code;
      end
    end
    win_fill = 0;
    acc = '{0, 0, 0};
    pending_results.push_back(r);
  endfunction

  // Offer one sample word and hold it until the block takes it. Stall is
  // read at the falling edge, where it has settled for the coming rising edge.
  task automatic send_sample(input afsd_in_t s);
    int gap;
    bit took;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
    fold_sample(s);
  endtask

  // Stop sending until every owed result is out, then give any sample that
  // is still moving through the pipe time to settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write. Valid is left high so back-to-back writes do not
  // toggle it within one step; the caller lowers it after the batch.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    bit took;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do begin
      @(negedge clk);
      took = cfg_ready;
      @(posedge clk);
    end while (!took);
    // Bits above a register's width are dropped; unknown indexes do nothing.
    case (idx)
      REG_SHAKE_THRESHOLD_SQ: thr_sq = data[THR_W-1:0];
      REG_SHAKE_HOLDOFF_US: holdoff = data[TIME_W-1:0];
      REG_SHAKE_ENABLE: shake_on = data[0];
      REG_FACE_ENABLE: face_on = data[0];
      default: ;
    endcase
  endtask

  // Write all four registers in a random order. Narrow registers get junk in
  // their unused upper bits, and sometimes an index past the end is written.
  task automatic program_regs(input logic [THR_W-1:0] thr, input logic [TIME_W-1:0] hold,
                              input bit sh, input bit fa);
    logic [CFG_IDX_W-1:0] order [4];
    logic [CFG_IDX_W-1:0] tmp;
    logic [CFG_DATA_W-1:0] data;
    int j;
    order = '{REG_SHAKE_THRESHOLD_SQ, REG_SHAKE_HOLDOFF_US, REG_SHAKE_ENABLE, REG_FACE_ENABLE};
    for (int k = 3; k > 0; k--) begin
      j = $urandom_range(k, 0);
      tmp = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    for (int k = 0; k < 4; k++) begin
      case (order[k])
        REG_SHAKE_THRESHOLD_SQ: data = thr;
        REG_SHAKE_HOLDOFF_US: data = {7'($urandom), hold};
        REG_SHAKE_ENABLE: data = {38'({$urandom, $urandom}), sh};
        default: data = {38'({$urandom, $urandom}), fa};
      endcase
      write_reg(order[k], data);
    end
    if ($urandom_range(0, 2) == 0) begin
      write_reg(CFG_IDX_W'($urandom_range(2 ** CFG_IDX_W - 1, REG_FACE_ENABLE + 1)),
                CFG_DATA_W'({$urandom, $urandom}));
    end
    cfg_valid <= 1'b0;
  endtask

  // Random but physically shaped samples. A motion pattern is picked at the
  // start of each window so that whole windows rest, shake, saturate, tie, lose
  // every read or carry noise; this is what reaches the shake and face decisions.
  function automatic afsd_in_t next_motion_sample();
    afsd_in_t s;
    int v [3];
    int pick;
    if (win_fill == 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) motion = MOTION_STILL;
      else if (pick < 60) motion = MOTION_SHAKE;
      else if (pick < 68) motion = MOTION_FULL;
      else if (pick < 75) motion = MOTION_DEAD;
      else if (pick < 85) motion = MOTION_TIE;
      else motion = MOTION_NOISE;
      m_axis = $urandom_range(0, 2);
      m_mag = (motion == MOTION_TIE) ? $urandom_range(1, 3276) : $urandom_range(900, 1100);
      for (int k = 0; k < 3; k++) m_sign[k] = $urandom_range(0, 1) ? 1 : -1;
      m_ztie = 1'($urandom_range(0, 1));
    end
    for (int k = 0; k < 3; k++) begin
      case (motion)
        MOTION_STILL: v[k] = int'($urandom_range(0, 120)) - 60;
        MOTION_FULL: v[k] = (m_sign[k] > 0) ? 32767 : -32768;
        MOTION_TIE: v[k] = m_sign[k] * m_mag;
        MOTION_NOISE: v[k] = int'($urandom_range(0, 4000)) - 2000;
        default: v[k] = $urandom;
      endcase
    end
    if (motion == MOTION_STILL) v[m_axis] += m_sign[m_axis] * m_mag;
    if (motion == MOTION_TIE && !m_ztie) v[2] = v[2] / 2;
    s.accel_x = 16'(v[0]);
    s.accel_y = 16'(v[1]);
    s.accel_z = 16'(v[2]);
    s.sample_ok = (motion == MOTION_DEAD) ? 1'b0 : ($urandom_range(0, 9) != 0);
    // Mostly steady time steps, with occasional jumps that wrap the clock.
    time_clock += ($urandom_range(0, 49) == 0) ? $urandom : $urandom_range(0, 20000);
    s.time_us = time_clock;
    return s;
  endfunction

  // The result side stalls in random bursts, at a rate set per phase.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if ($urandom_range(0, 99) < sink_stall_pct) begin
      out_stall <= 1'b1;
      stall_left = pick_len() - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Result monitor: the handshake is sampled at the falling edge and counted
  // at the following rising edge, where the word is taken.
  afsd_out_t mon_word;
  bit mon_take = 1'b0;

  always @(negedge clk) begin
    mon_take = rst_n && out_valid && !out_stall;
    mon_word = out_data;
  end

  function automatic void check_result(input afsd_out_t got);
    afsd_out_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: result word with nothing expected, got %p", $time, got);
      mismatches++;
      return;
    end
    want = pending_results.pop_front();
    if (got.shake_event !== want.shake_event) begin
      $display("%0t: shake_event expected %0b, got %0b", $time, want.shake_event,
               got.shake_event);
      mismatches++;
    end
    if (got.face_changed !== want.face_changed) begin
      $display("%0t: face_changed expected %0b, got %0b", $time, want.face_changed,
               got.face_changed);
      mismatches++;
    end
    if (got.face_code !== want.face_code) begin
      $display("%0t: face_code expected %0d, got %0d", $time, want.face_code, got.face_code);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (mon_take) check_result(mon_word);
  end

  // Reset values with both detectors off: results must report no shake and
  // the untouched face. Full-scale values, all-ones and alternating bit
  // patterns, both timestamp extremes and failed reads go through here.
  task automatic test_detectors_off_extremes();
    send_sample(mk(16'h7FFF, 16'h8000, 16'h0000, 1'b1, 32'h0000_0000));
    send_sample(mk(16'h8000, 16'h7FFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF));
    send_sample(mk(16'hFFFF, 16'h0000, 16'h7FFF, 1'b1, 32'h5555_5555));
    send_sample(mk(16'h5555, 16'hAAAA, 16'h5555, 1'b1, 32'hAAAA_AAAA));
    send_sample(mk(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, 32'h0000_0001));
    send_sample(mk(16'h8000, 16'h8000, 16'h8000, 1'b0, 32'h8000_0000));
    repeat (4) begin
      send_sample(mk(16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom),
                     $urandom));
    end
  endtask

  // Ten samples at negative full scale on every axis: the energy equals the
  // programmed threshold exactly, so the strict compare must not report a shake,
  // and the three-way tie must settle on the x axis.
  task automatic test_full_scale_tie();
    wait_drained();
    program_regs(FULL_SCALE_ENERGY, '0, 1'b1, 1'b1);
    for (int k = 0; k < SAMPLES_PER_WINDOW; k++) begin
      send_sample(mk(16'h8000, 16'h8000, 16'h8000, 1'b1, 32'(1000 + k)));
    end
    // Hold the sender until the window's result is out.
    wait_drained();
  endtask

  task automatic run_phase(input logic [THR_W-1:0] thr, input logic [TIME_W-1:0] hold,
                           input bit sh, input bit fa, input int n,
                           input int gap_pct, input int stall_pct);
    wait_drained();
    sender_gap_pct = gap_pct;
    sink_stall_pct = stall_pct;
    program_regs(thr, hold, sh, fa);
    repeat (n) begin
      if (pending_results.size() != 0 && $urandom_range(0, 99) == 0) wait_drained();
      send_sample(next_motion_sample());
    end
  endtask

  // Settings sweep: reset values, both threshold and holdoff extremes, each
  // detector alone, and random settings, under different idling mixes.
  task automatic test_random_motion();
    time_clock = $urandom;
    run_phase(THRESHOLD_RESET, HOLDOFF_RESET, 1'b1, 1'b1, 240, 0, 0);
    run_phase('0, '0, 1'b1, 1'b1, 240, 30, 30);
    run_phase(FULL_SCALE_ENERGY, '1, 1'b1, 1'b1, 240, 15, 15);
    run_phase(THR_W'($urandom_range(1000, 30000)) * 39'd1000000,
              $urandom_range(0, 300000), 1'b1, 1'b1, 240, 10, 70);
    run_phase(THRESHOLD_RESET, $urandom_range(0, 200000), 1'b1, 1'b0, 240, 20, 20);
    run_phase(THRESHOLD_RESET, HOLDOFF_RESET, 1'b0, 1'b1, 240, 50, 10);
    run_phase(THR_W'({$urandom, $urandom}) % (FULL_SCALE_ENERGY + 1), $urandom,
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 240, 25, 25);
    run_phase(39'd1000000000, 32'd100000, 1'b1, 1'b1, 240, 5, 40);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_detectors_off_extremes();
    test_full_scale_tie();
    test_random_motion();
    wait_drained();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

endmodule
